// File: hw/rtl/hbs_pkg.sv
package hbs_pkg;

	localparam int unsigned HEIGHT_W = 16;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned SCALE_W  = 10;
	localparam int unsigned RESULT_W = 26;

	typedef struct packed {
		logic valid;
		logic outside;
	} blend_ctl_t;

endpackage

// File: hw/rtl/bilinear_height_sampler.sv
// Bilinear height sampler.
// Items enter on start with opcode, entry_index, entry_height, world_x and world_z;
// busy is always low, so an item is taken at every edge where start is high.
// A write item (opcode 0) stores entry_height at entry_index and gives no result.
// A sample item (opcode 1) gives one result: done pulses for one cycle with
// terrain_height (unsigned integer, Q26.0, rounded) and sample_status (1 = cell outside the map, height 0).
// A sample passes every pipeline stage and then the output register; nothing stalls it.
// Throughput: one item per cycle, reads and writes mixed in any order; a write
// is seen by every sample accepted after it.
// Four corner heights are read per cycle from two copies of the map, each with
// two read ports; both copies take every write.
// Registers on the APB port: 0x0 grid_side, 0x4 inverse_spacing, 0x8 height_scale.
// Write them only with no item in flight.
// Reset clears the pipeline and loads the register defaults; map contents are
// undefined until written. There is no back pressure on the result side.
module bilinear_height_sampler #(
	parameter int unsigned MAP_SIDE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [15:0]                   entry_index,
	input  logic [hbs_pkg::HEIGHT_W-1:0]  entry_height,
	input  logic [15:0]                   world_x,
	input  logic [15:0]                   world_z,
	output logic                          done,
	output logic [hbs_pkg::RESULT_W-1:0]  terrain_height,
	output logic                          sample_status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(MAP_SIDE);
	localparam int unsigned SW    = $clog2(MAP_SIDE + 1);
	localparam int unsigned HW    = hbs_pkg::HEIGHT_W;
	localparam int unsigned FW    = hbs_pkg::FRAC_W;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] REG_GRID_SIDE    = 2'd0;
	localparam logic [1:0] REG_INV_SPACING  = 2'd1;
	localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

	localparam logic [8:0]                  GRID_SIDE_RST = 9'd256;
	localparam logic [15:0]                 INV_SPACING_RST = 16'd1311;
	localparam logic [hbs_pkg::SCALE_W-1:0] HEIGHT_SCALE_RST = 10'd175;

	// ---------------- configuration ----------------
	logic [8:0]                  grid_side_q;
	logic [15:0]                 inv_spacing_q;
	logic [hbs_pkg::SCALE_W-1:0] height_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q    <= GRID_SIDE_RST;
			inv_spacing_q  <= INV_SPACING_RST;
			height_scale_q <= HEIGHT_SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_GRID_SIDE:    grid_side_q    <= pwdata[8:0];
				REG_INV_SPACING:  inv_spacing_q  <= pwdata[15:0];
				REG_HEIGHT_SCALE: height_scale_q <= pwdata[hbs_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GRID_SIDE:    prdata = 32'(grid_side_q);
			REG_INV_SPACING:  prdata = 32'(inv_spacing_q);
			REG_HEIGHT_SCALE: prdata = 32'(height_scale_q);
			default:          prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	logic [SW-1:0] side;
	assign side = (32'(grid_side_q) > MAP_SIDE) ? SW'(MAP_SIDE) : SW'(grid_side_q);

	// ---------------- stage 1: scale position to cell units ----------------
	logic [31:0] px_c, pz_c;
	assign px_c = 32'(world_x) * 32'(inv_spacing_q);
	assign pz_c = 32'(world_z) * 32'(inv_spacing_q);

	logic          valid_s1, op_s1, wr_ok_s1;
	logic [31:0]   px_s1, pz_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [HW-1:0] wr_data_s1;

	// ---------------- stage 2: cell, fraction, neighbors ----------------
	logic [15:0]   col_full, row_full;
	logic          outside_c;
	logic [CW-1:0] col0_c, row0_c, col1_c, row1_c;
	logic [SW-1:0] col_inc, row_inc;

	assign col_full  = px_s1[31:16];
	assign row_full  = pz_s1[31:16];
	assign outside_c = (col_full >= 16'(side)) || (row_full >= 16'(side));
	assign col0_c    = CW'(col_full);
	assign row0_c    = CW'(row_full);
	assign col_inc   = SW'(col0_c) + SW'(1);
	assign row_inc   = SW'(row0_c) + SW'(1);
	// next column or row wraps to 0 at the edge of the map in use
	assign col1_c    = (col_inc >= side) ? '0 : CW'(col_inc);
	assign row1_c    = (row_inc >= side) ? '0 : CW'(row_inc);

	logic          valid_s2, op_s2, outside_s2, wr_ok_s2;
	logic [CW-1:0] col0_s2, col1_s2, row0_s2, row1_s2;
	logic [FW-1:0] fx_s2, fz_s2;
	logic [AW-1:0] wr_addr_s2;
	logic [HW-1:0] wr_data_s2;

	// ---------------- stage 3: row base addresses ----------------
	logic [CW+SW-1:0] base0_c, base1_c;
	assign base0_c = (CW + SW)'(row0_s2) * (CW + SW)'(side);
	assign base1_c = (CW + SW)'(row1_s2) * (CW + SW)'(side);

	logic          valid_s3, op_s3, outside_s3, wr_ok_s3;
	logic [AW-1:0] base0_s3, base1_s3;
	logic [CW-1:0] col0_s3, col1_s3;
	logic [FW-1:0] fx_s3, fz_s3;
	logic [AW-1:0] wr_addr_s3;
	logic [HW-1:0] wr_data_s3;

	// writes and reads share this stage, so map order follows item order
	logic          ram_we;
	logic [AW-1:0] addr00, addr01, addr10, addr11;
	assign ram_we = valid_s3 && (op_s3 == OP_WRITE) && wr_ok_s3;
	assign addr00 = base0_s3 + AW'(col0_s3);
	assign addr01 = base0_s3 + AW'(col1_s3);
	assign addr10 = base1_s3 + AW'(col0_s3);
	assign addr11 = base1_s3 + AW'(col1_s3);

	// ---------------- stage 4: corner heights from the map ----------------
	hbs_pkg::blend_ctl_t ctl_s4;
	logic [FW-1:0]       fx_s4, fz_s4;
	logic [HW-1:0]       h00, h01, h10, h11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
		end else begin
			valid_s1       <= start;
			valid_s2       <= valid_s1;
			valid_s3       <= valid_s2;
			ctl_s4.valid   <= valid_s3 && (op_s3 == OP_SAMPLE);
			ctl_s4.outside <= outside_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1          <= opcode;
		px_s1          <= px_c;
		pz_s1          <= pz_c;
		wr_ok_s1       <= 32'(entry_index) < DEPTH;
		wr_addr_s1     <= AW'(entry_index);
		wr_data_s1     <= entry_height;

		op_s2          <= op_s1;
		outside_s2     <= outside_c;
		col0_s2        <= col0_c;
		col1_s2        <= col1_c;
		row0_s2        <= row0_c;
		row1_s2        <= row1_c;
		fx_s2          <= px_s1[FW-1:0];
		fz_s2          <= pz_s1[FW-1:0];
		wr_ok_s2       <= wr_ok_s1;
		wr_addr_s2     <= wr_addr_s1;
		wr_data_s2     <= wr_data_s1;

		op_s3          <= op_s2;
		outside_s3     <= outside_s2;
		base0_s3       <= AW'(base0_c);
		base1_s3       <= AW'(base1_c);
		col0_s3        <= col0_s2;
		col1_s3        <= col1_s2;
		fx_s3          <= fx_s2;
		fz_s3          <= fz_s2;
		wr_ok_s3       <= wr_ok_s2;
		wr_addr_s3     <= wr_addr_s2;
		wr_data_s3     <= wr_data_s2;

		fx_s4          <= fx_s3;
		fz_s4          <= fz_s3;
	end

	hbs_ram #(
		.WIDTH(HW),
		.DEPTH(DEPTH)
	) u_ram_row0 (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (wr_addr_s3),
		.wdata  (wr_data_s3),
		.raddr_a(addr00),
		.rdata_a(h00),
		.raddr_b(addr01),
		.rdata_b(h01)
	);

	hbs_ram #(
		.WIDTH(HW),
		.DEPTH(DEPTH)
	) u_ram_row1 (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (wr_addr_s3),
		.wdata  (wr_data_s3),
		.raddr_a(addr10),
		.rdata_a(h10),
		.raddr_b(addr11),
		.rdata_b(h11)
	);

	// ---------------- stages 5..7 and output register ----------------
	hbs_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s4        (ctl_s4),
		.h00           (h00),
		.h01           (h01),
		.h10           (h10),
		.h11           (h11),
		.fx_s4         (fx_s4),
		.fz_s4         (fz_s4),
		.height_scale  (height_scale_q),
		.done          (done),
		.terrain_height(terrain_height),
		.sample_status (sample_status)
	);

`ifndef SYNTHESIS
	// every accepted sample item gives a result strobe
	a_sample_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && (opcode == OP_SAMPLE) |-> ##8 done)
		else $error("sample item produced no result");

	a_write_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && (opcode == OP_WRITE) |-> ##8 !done)
		else $error("write item produced a result");

	a_outside_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && sample_status |-> terrain_height == '0)
		else $error("outside sample with nonzero height");
`endif

endmodule

// File: hw/rtl/hbs_ram.sv
module hbs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hw/rtl/hbs_blend.sv
module hbs_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbs_pkg::blend_ctl_t           ctl_s4,
	input  logic [hbs_pkg::HEIGHT_W-1:0]  h00,
	input  logic [hbs_pkg::HEIGHT_W-1:0]  h01,
	input  logic [hbs_pkg::HEIGHT_W-1:0]  h10,
	input  logic [hbs_pkg::HEIGHT_W-1:0]  h11,
	input  logic [hbs_pkg::FRAC_W-1:0]    fx_s4,
	input  logic [hbs_pkg::FRAC_W-1:0]    fz_s4,
	input  logic [hbs_pkg::SCALE_W-1:0]   height_scale,
	output logic                          done,
	output logic [hbs_pkg::RESULT_W-1:0]  terrain_height,
	output logic                          sample_status
);

	localparam int unsigned HW      = hbs_pkg::HEIGHT_W;
	localparam int unsigned FW      = hbs_pkg::FRAC_W;
	localparam int unsigned TOP_W   = HW + FW;
	localparam int unsigned BLEND_W = TOP_W + FW;
	localparam int unsigned PROD_W  = BLEND_W + hbs_pkg::SCALE_W;
	localparam logic [PROD_W:0] ROUND = (PROD_W + 1)'(1) << (2 * FW - 1);

	// row blends: h0*(1-f) + h1*f == h0<<16 + (h1-h0)*f
	logic signed [HW:0]      dtop, dbot;
	logic signed [FW:0]      fxs;
	logic signed [TOP_W+1:0] ptop, pbot, top_c, bot_c;

	assign dtop  = $signed({1'b0, h01}) - $signed({1'b0, h00});
	assign dbot  = $signed({1'b0, h11}) - $signed({1'b0, h10});
	assign fxs   = $signed({1'b0, fx_s4});
	assign ptop  = dtop * fxs;
	assign pbot  = dbot * fxs;
	assign top_c = $signed({2'b00, h00, {FW{1'b0}}}) + ptop;
	assign bot_c = $signed({2'b00, h10, {FW{1'b0}}}) + pbot;

	hbs_pkg::blend_ctl_t ctl_s5, ctl_s6, ctl_s7;
	logic [TOP_W-1:0]   top_s5, bot_s5;
	logic [FW-1:0]      fz_s5;
	logic [BLEND_W-1:0] blend_s6;
	logic [PROD_W-1:0]  prod_s7;

	// column blend, same form
	logic signed [TOP_W:0]     dcol;
	logic signed [FW:0]        fzs;
	logic signed [BLEND_W+1:0] pcol, blend_c;

	assign dcol    = $signed({1'b0, bot_s5}) - $signed({1'b0, top_s5});
	assign fzs     = $signed({1'b0, fz_s5});
	assign pcol    = dcol * fzs;
	assign blend_c = $signed({2'b00, top_s5, {FW{1'b0}}}) + pcol;

	logic [PROD_W-1:0] prod_c;
	logic [PROD_W:0]   round_sum;

	assign prod_c    = PROD_W'(blend_s6) * PROD_W'(height_scale);
	assign round_sum = (PROD_W + 1)'(prod_s7) + ROUND;

	logic                        done_q;
	logic [hbs_pkg::RESULT_W-1:0] result_q;
	logic                        status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			done_q <= ctl_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		top_s5         <= top_c[TOP_W-1:0];
		bot_s5         <= bot_c[TOP_W-1:0];
		fz_s5          <= fz_s4;
		blend_s6       <= blend_c[BLEND_W-1:0];
		prod_s7        <= prod_c;
		result_q       <= ctl_s7.outside ? '0 : round_sum[2*FW +: hbs_pkg::RESULT_W];
		status_q       <= ctl_s7.outside;
	end

	assign done           = done_q;
	assign terrain_height = result_q;
	assign sample_status  = status_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned MAP_SIDE = 256;
	// the limit keeps a wide margin over the longest run
	localparam int unsigned LIMIT = 400000;

	localparam bit OP_WRITE  = 1'b0;
	localparam bit OP_SAMPLE = 1'b1;

	localparam bit STATUS_OK      = 1'b0;
	localparam bit STATUS_OUTSIDE = 1'b1;

	localparam int REG_GRID_SIDE    = 0;
	localparam int REG_INV_SPACING  = 1;
	localparam int REG_HEIGHT_SCALE = 2;

	localparam int PHASES = 12;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         opcode;
	logic [15:0]                  entry_index;
	logic [hbs_pkg::HEIGHT_W-1:0] entry_height;
	logic [15:0]                  world_x;
	logic [15:0]                  world_z;
	logic                         done;
	logic [hbs_pkg::RESULT_W-1:0] terrain_height;
	logic                         sample_status;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [3:0]                   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	bilinear_height_sampler #(.MAP_SIDE(MAP_SIDE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_index(entry_index),
		.entry_height(entry_height),
		.world_x(world_x),
		.world_z(world_z),
		.done(done),
		.terrain_height(terrain_height),
		.sample_status(sample_status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	typedef struct {
		bit [hbs_pkg::RESULT_W-1:0] height;
		bit                         status;
	} sample_result_t;

	class height_sampler_mirror;
		bit [15:0]      heights [0:65535];
		bit             written [0:65535];
		bit [8:0]       grid_side = 9'd256;
		bit [15:0]      inv_spacing = 16'd1311;
		bit [9:0]       scale = 10'd175;
		sample_result_t pending_heights [$];
		int             errors;

		function void set_reg(int idx, bit [31:0] value);
			case (idx)
				REG_GRID_SIDE:    grid_side = value[8:0];
				REG_INV_SPACING:  inv_spacing = value[15:0];
				REG_HEIGHT_SCALE: scale = value[9:0];
				default: ;
			endcase
		endfunction

		function int unsigned side_used();
			return (grid_side > MAP_SIDE) ? MAP_SIDE : grid_side;
		endfunction

		// cell lookup: corner order is (r0,c0) (r0,c1) (r1,c0) (r1,c1)
		function void locate(input bit [15:0] wx, input bit [15:0] wz, output bit outside,
				output bit [3:0][15:0] corner, output bit [15:0] fx, output bit [15:0] fz);
			bit [31:0]   px;
			bit [31:0]   pz;
			int unsigned side;
			int unsigned col0;
			int unsigned row0;
			int unsigned col1;
			int unsigned row1;
			side = side_used();
			px = 32'(wx) * 32'(inv_spacing);
			pz = 32'(wz) * 32'(inv_spacing);
			col0 = px[31:16];
			row0 = pz[31:16];
			fx = px[15:0];
			fz = pz[15:0];
			outside = (col0 >= side) || (row0 >= side);
			col1 = (col0 + 1 >= side) ? 0 : col0 + 1;
			row1 = (row0 + 1 >= side) ? 0 : row0 + 1;
			corner[0] = 16'(row0 * side + col0);
			corner[1] = 16'(row0 * side + col1);
			corner[2] = 16'(row1 * side + col0);
			corner[3] = 16'(row1 * side + col1);
		endfunction

		function void note_item(bit op, bit [15:0] idx, bit [15:0] h, bit [15:0] wx,
				bit [15:0] wz);
			bit              outside;
			bit [3:0][15:0]  corner;
			bit [15:0]       fx;
			bit [15:0]       fz;
			bit [63:0]       fx64;
			bit [63:0]       fz64;
			bit [63:0]       top;
			bit [63:0]       bot;
			bit [63:0]       blend;
			bit [63:0]       scaled;
			sample_result_t  r;
			if (op == OP_WRITE) begin
				heights[idx] = h;
				written[idx] = 1'b1;
				return;
			end
			locate(wx, wz, outside, corner, fx, fz);
			if (outside) begin
				r.height = '0;
				r.status = STATUS_OUTSIDE;
			end else begin
				fx64 = 64'(fx);
				fz64 = 64'(fz);
				top = 64'(heights[corner[0]]) * (64'd65536 - fx64)
					+ 64'(heights[corner[1]]) * fx64;
				bot = 64'(heights[corner[2]]) * (64'd65536 - fx64)
					+ 64'(heights[corner[3]]) * fx64;
				blend = top * (64'd65536 - fz64) + bot * fz64;
				scaled = (blend * 64'(scale) + 64'h8000_0000) >> 32;
				r.height = scaled[hbs_pkg::RESULT_W-1:0];
				r.status = STATUS_OK;
			end
			pending_heights.insert(pending_heights.size(), r);
		endfunction

		function void check_result(logic [hbs_pkg::RESULT_W-1:0] height, logic status);
			sample_result_t e;
			if (pending_heights.size() == 0) begin
				$display("%0t: result with no sample waiting: height %0d status %0d",
					$time, height, status);
				errors++;
				return;
			end
			e = pending_heights.pop_front();
			if (height !== e.height) begin
				$display("%0t: terrain_height expected %0d, got %0d", $time, e.height, height);
				errors++;
			end
			if (status !== e.status) begin
				$display("%0t: sample_status expected %0d, got %0d", $time, e.status, status);
				errors++;
			end
		endfunction
	endclass

	height_sampler_mirror mirror;
	bit                   steady;
	int unsigned          cycles;

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout, %0d samples still waiting", $time,
				mirror.pending_heights.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done === 1'b1)
			mirror.check_result(terrain_height, sample_status);
	end

	task automatic send_item(input bit op, input bit [15:0] idx, input bit [15:0] h,
			input bit [15:0] wx, input bit [15:0] wz);
		while (!steady && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		opcode       <= op;
		entry_index  <= idx;
		entry_height <= h;
		world_x      <= wx;
		world_z      <= wz;
		do @(posedge clk); while (busy !== 1'b0);
		mirror.note_item(op, idx, h, wx, wz);
		@(negedge clk);
	endtask

	// fill any unwritten corner first so the sample never reads an undefined entry
	task automatic sample_at(input bit [15:0] wx, input bit [15:0] wz);
		bit             outside;
		bit [3:0][15:0] corner;
		bit [15:0]      fx;
		bit [15:0]      fz;
		mirror.locate(wx, wz, outside, corner, fx, fz);
		if (!outside) begin
			for (int k = 0; k < 4; k++) begin
				if (!mirror.written[corner[k]])
					send_item(OP_WRITE, corner[k],
						($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom),
						16'($urandom), 16'($urandom));
			end
		end
		send_item(OP_SAMPLE, 16'($urandom), 16'($urandom), wx, wz);
	endtask

	// mostly positions that land inside the map, a little past the edge too
	function automatic bit [15:0] pick_coord();
		int unsigned span;
		if (mirror.inv_spacing == 0)
			span = 65535;
		else
			span = mirror.side_used() * 65536 / mirror.inv_spacing + 1;
		if (span > 65535)
			span = 65535;
		return 16'($urandom_range(span, 0));
	endfunction

	task automatic random_step();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			send_item(OP_WRITE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		else if (r < 25)
			sample_at(16'($urandom), 16'($urandom));
		else
			sample_at(pick_coord(), pick_coord());
	endtask

	task automatic apb_write(input int idx, input bit [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		mirror.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// writes give no result, so allow the pipeline depth after the last sample
	task automatic drain();
		start <= 1'b0;
		while (mirror.pending_heights.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	initial begin
		int unsigned side_tab [8]  = '{2, 1, 0, 511, 16, 256, 5, 300};
		int unsigned inv_tab [8]   = '{65535, 4000, 1311, 1311, 0, 1, 20000, 9000};
		int unsigned scale_tab [8] = '{1023, 1, 175, 1023, 300, 0, 512, 77};
		bit [31:0]   side_val;
		bit [31:0]   inv_val;
		bit [31:0]   scale_val;

		mirror       = new();
		steady       = 1'b0;
		cycles       = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = OP_WRITE;
		entry_index  = '0;
		entry_height = '0;
		world_x      = '0;
		world_z      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values
		send_item(OP_WRITE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
		send_item(OP_WRITE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_item(OP_WRITE, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		send_item(OP_WRITE, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
		sample_at(16'd0, 16'd0);
		sample_at(16'd12748, 16'd12748);   // last cell: both neighbors wrap
		sample_at(16'd12783, 16'd0);
		sample_at(16'd12799, 16'd12799);   // just past the map
		sample_at(16'hFFFF, 16'd0);
		sample_at(16'd0, 16'hFFFF);
		sample_at(16'hFFFF, 16'hFFFF);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p < 8) begin
				side_val  = side_tab[p];
				inv_val   = inv_tab[p];
				scale_val = scale_tab[p];
			end else begin
				// junk in the unused upper bits
				side_val  = ($urandom_range(3) == 0) ? $urandom_range(256, 2)
					: $urandom_range(24, 2);
				side_val  = {23'($urandom_range(32'h7F_FFFF)), side_val[8:0]};
				inv_val   = {16'($urandom), 16'($urandom_range(65535, 1))};
				scale_val = {22'($urandom), 10'($urandom_range(1023))};
			end
			apb_write(REG_GRID_SIDE, side_val);
			apb_write(REG_INV_SPACING, inv_val);
			apb_write(REG_HEIGHT_SCALE, scale_val);
			steady = (p == 3 || p == 9);
			repeat (85) random_step();
		end

		drain();
		if (mirror.errors == 0 && mirror.pending_heights.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
